FILE: hw/rtl/hsmc_pkg.sv
// Shared types and codes for the handle-to-slot map compactor.
// Used by the controller, the datapath and the port checker.
package hsmc_pkg;

    localparam logic [1:0] ACT_ADD = 2'd0;
    localparam logic [1:0] ACT_DEL = 2'd1;
    localparam logic [1:0] ACT_RES = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_NOHANDLE = 2'd2;

    typedef enum logic [1:0] {
        RD_NONE,
        RD_HANDLE,
        RD_SCAN
    } rd_src_t;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_ADD,
        WR_MOVE,
        WR_FREE,
        WR_CLEAR
    } wr_kind_t;

    typedef enum logic [2:0] {
        OUT_NONE,
        OUT_FULL,
        OUT_NOHANDLE,
        OUT_RESOLVE,
        OUT_ADD,
        OUT_DELETE
    } out_kind_t;

    typedef struct packed {
        logic      capture;
        logic      scan_clr;
        logic      scan_step;
        rd_src_t   rd_src;
        wr_kind_t  wr_kind;
        logic      dest_load;
        logic      move_set;
        out_kind_t out_kind;
    } cmd_t;

    typedef struct packed {
        logic [1:0] act;
        logic       full;
        logic       h_in_range;
        logic       rd_fresh;
        logic       rd_valid;
        logic       rd_is_last;
        logic       scan_end;
        logic       clear_end;
    } sts_t;

endpackage

FILE: hw/rtl/hsmc_datapath.sv
// Datapath of the handle-to-slot map compactor: handle table memory, scan index,
// slot count and result registers. Depends on hsmc_pkg; driven by hsmc_ctrl.
module hsmc_datapath import hsmc_pkg::*; #(
    parameter int SLOTS = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    input  cmd_t       cmd,
    output sts_t       sts,
    input  logic [1:0] action,
    input  logic [5:0] handle,
    output logic [1:0] status,
    output logic [5:0] handle_out,
    output logic [5:0] slot,
    output logic       move_valid,
    output logic [5:0] move_from,
    output logic [6:0] used_count
);

    localparam int IW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);

    logic [IW:0]    mem [SLOTS];

    logic [1:0]     action_reg;
    logic [5:0]     handle_reg;
    logic [IW-1:0]  scan_idx_reg, scan_idx_next;
    logic [IW-1:0]  rd_idx_reg;
    logic [IW:0]    rd_data_reg;
    logic           rd_fresh_reg;
    logic [IW-1:0]  dest_reg;
    logic           mv_reg;
    logic [CW-1:0]  count_reg, count_next;

    logic [1:0]     status_reg, status_next;
    logic [5:0]     handle_out_reg, handle_out_next;
    logic [5:0]     slot_reg, slot_next;
    logic           move_valid_reg, move_valid_next;
    logic [5:0]     move_from_reg, move_from_next;
    logic [6:0]     used_count_reg, used_count_next;

    logic [IW+5:0]  h_wide;
    logic [IW-1:0]  h_idx;
    logic [CW-1:0]  last_c;
    logic [IW-1:0]  last;
    logic [IW-1:0]  rd_addr;
    logic           rd_en;
    logic           wr_en;
    logic [IW-1:0]  wr_addr;
    logic [IW:0]    wr_data;
    logic [IW+5:0]  rd_idx_w, rd_slot_w, cnt_slot_w, dest_w, last_w;
    logic [CW+6:0]  cnt_next_w, cnt_w;

    assign h_wide  = {{IW{1'b0}}, handle_reg};
    assign h_idx   = h_wide[IW-1:0];
    assign last_c  = count_reg - CW'(1);
    assign last    = last_c[IW-1:0];
    assign rd_en   = (cmd.rd_src != RD_NONE);
    assign rd_addr = (cmd.rd_src == RD_HANDLE) ? h_idx : scan_idx_reg;

    assign sts.act        = action_reg;
    assign sts.full       = (count_reg == CW'(SLOTS));
    assign sts.h_in_range = (32'(handle_reg) < 32'(SLOTS));
    assign sts.rd_fresh   = rd_fresh_reg;
    assign sts.rd_valid   = rd_data_reg[IW];
    assign sts.rd_is_last = (rd_data_reg[IW-1:0] == last);
    assign sts.scan_end   = (rd_idx_reg == IW'(SLOTS - 1));
    assign sts.clear_end  = (scan_idx_reg == IW'(SLOTS - 1));

    always_comb
    begin
        if (cmd.scan_clr)
        begin
            scan_idx_next = '0;
        end
        else if (cmd.scan_step)
        begin
            scan_idx_next = (scan_idx_reg == IW'(SLOTS - 1)) ? '0 : scan_idx_reg + IW'(1);
        end
        else
        begin
            scan_idx_next = scan_idx_reg;
        end
    end

    always_comb
    begin
        wr_en      = 1'b0;
        wr_addr    = rd_idx_reg;
        wr_data    = '0;
        count_next = count_reg;
        case (cmd.wr_kind)
            WR_ADD:
            begin
                wr_en      = 1'b1;
                wr_addr    = rd_idx_reg;
                wr_data    = {1'b1, count_reg[IW-1:0]};
                count_next = count_reg + CW'(1);
            end
            WR_MOVE:
            begin
                wr_en   = 1'b1;
                wr_addr = rd_idx_reg;
                wr_data = {1'b1, dest_reg};
            end
            WR_FREE:
            begin
                wr_en      = 1'b1;
                wr_addr    = h_idx;
                wr_data    = '0;
                count_next = count_reg - CW'(1);
            end
            WR_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = scan_idx_reg;
                wr_data = '0;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    assign rd_idx_w   = {6'b0, rd_idx_reg};
    assign rd_slot_w  = {6'b0, rd_data_reg[IW-1:0]};
    assign cnt_slot_w = {6'b0, count_reg[IW-1:0]};
    assign dest_w     = {6'b0, dest_reg};
    assign last_w     = {6'b0, last};
    assign cnt_next_w = {7'b0, count_next};
    assign cnt_w      = {7'b0, count_reg};

    always_comb
    begin
        status_next     = ST_OK;
        handle_out_next = handle_reg;
        slot_next       = '0;
        move_valid_next = 1'b0;
        move_from_next  = '0;
        used_count_next = cnt_w[6:0];
        case (cmd.out_kind)
            OUT_FULL:
            begin
                status_next = ST_FULL;
            end
            OUT_NOHANDLE:
            begin
                status_next = ST_NOHANDLE;
            end
            OUT_RESOLVE:
            begin
                slot_next = rd_slot_w[5:0];
            end
            OUT_ADD:
            begin
                handle_out_next = rd_idx_w[5:0];
                slot_next       = cnt_slot_w[5:0];
                used_count_next = cnt_next_w[6:0];
            end
            OUT_DELETE:
            begin
                slot_next       = dest_w[5:0];
                move_valid_next = mv_reg;
                move_from_next  = mv_reg ? last_w[5:0] : 6'b0;
                used_count_next = cnt_next_w[6:0];
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg <= '0;
            rd_fresh_reg <= 1'b0;
            count_reg    <= '0;
        end
        else
        begin
            scan_idx_reg <= scan_idx_next;
            rd_fresh_reg <= rd_en;
            count_reg    <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
            rd_idx_reg  <= rd_addr;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            action_reg <= action;
            handle_reg <= handle;
        end
        if (cmd.capture)
        begin
            mv_reg <= 1'b0;
        end
        else if (cmd.move_set)
        begin
            mv_reg <= 1'b1;
        end
        if (cmd.dest_load)
        begin
            dest_reg <= rd_data_reg[IW-1:0];
        end
        if (cmd.out_kind != OUT_NONE)
        begin
            status_reg     <= status_next;
            handle_out_reg <= handle_out_next;
            slot_reg       <= slot_next;
            move_valid_reg <= move_valid_next;
            move_from_reg  <= move_from_next;
            used_count_reg <= used_count_next;
        end
    end

    assign status     = status_reg;
    assign handle_out = handle_out_reg;
    assign slot       = slot_reg;
    assign move_valid = move_valid_reg;
    assign move_from  = move_from_reg;
    assign used_count = used_count_reg;

endmodule

FILE: hw/rtl/hsmc_ctrl.sv
// Controller state machine of the handle-to-slot map compactor.
// Depends on hsmc_pkg; sequences hsmc_datapath through cmd_t and sts_t.
module hsmc_ctrl import hsmc_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    output logic out_valid,
    input  logic out_stall,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_LOOK,
        S_ASCAN,
        S_DSCAN,
        S_FREE
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '{capture: 1'b0, scan_clr: 1'b0, scan_step: 1'b0, rd_src: RD_NONE,
                       wr_kind: WR_NONE, dest_load: 1'b0, move_set: 1'b0,
                       out_kind: OUT_NONE};
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.wr_kind   = WR_CLEAR;
                cmd.scan_step = 1'b1;
                if (sts.clear_end)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (!out_valid_reg)
                begin
                    if (sts.act == ACT_ADD)
                    begin
                        if (sts.full)
                        begin
                            cmd.out_kind = OUT_FULL;
                            state_next   = S_IDLE;
                        end
                        else
                        begin
                            cmd.scan_clr = 1'b1;
                            state_next   = S_ASCAN;
                        end
                    end
                    else if (!sts.h_in_range)
                    begin
                        cmd.out_kind = OUT_NOHANDLE;
                        state_next   = S_IDLE;
                    end
                    else
                    begin
                        cmd.rd_src = RD_HANDLE;
                        state_next = S_LOOK;
                    end
                end
            end
            S_LOOK:
            begin
                if (!sts.rd_valid)
                begin
                    cmd.out_kind = OUT_NOHANDLE;
                    state_next   = S_IDLE;
                end
                else if (sts.act == ACT_DEL)
                begin
                    cmd.dest_load = 1'b1;
                    if (sts.rd_is_last)
                    begin
                        state_next = S_FREE;
                    end
                    else
                    begin
                        cmd.scan_clr = 1'b1;
                        state_next   = S_DSCAN;
                    end
                end
                else
                begin
                    cmd.out_kind = OUT_RESOLVE;
                    state_next   = S_IDLE;
                end
            end
            S_ASCAN:
            begin
                cmd.rd_src    = RD_SCAN;
                cmd.scan_step = 1'b1;
                if (sts.rd_fresh && !sts.rd_valid)
                begin
                    cmd.wr_kind  = WR_ADD;
                    cmd.out_kind = OUT_ADD;
                    state_next   = S_IDLE;
                end
                else if (sts.rd_fresh && sts.scan_end)
                begin
                    cmd.out_kind = OUT_FULL;
                    state_next   = S_IDLE;
                end
            end
            S_DSCAN:
            begin
                cmd.rd_src    = RD_SCAN;
                cmd.scan_step = 1'b1;
                if (sts.rd_fresh && sts.rd_valid && sts.rd_is_last)
                begin
                    cmd.wr_kind  = WR_MOVE;
                    cmd.move_set = 1'b1;
                    state_next   = S_FREE;
                end
                else if (sts.rd_fresh && sts.scan_end)
                begin
                    state_next = S_FREE;
                end
            end
            S_FREE:
            begin
                cmd.wr_kind  = WR_FREE;
                cmd.out_kind = OUT_DELETE;
                state_next   = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_kind != OUT_NONE)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

FILE: hw/rtl/handle_slot_map_compactor_top.sv
// Handle-to-slot map compactor, top level: joins hsmc_ctrl and hsmc_datapath.
// Each transaction ends in a registered result. An add scans the table for a free entry; a
// delete of a slot other than the last scans for the entry that holds the last slot. A scan
// stops at table index SLOTS-1 at the latest and reads one entry per cycle from one port.
// Throughput: one item at a time; the next transaction is taken the cycle after the result
// is registered and held until that result is taken. Reset: table clear, in_stall high.
module handle_slot_map_compactor_top import hsmc_pkg::*; #(
    parameter int SLOTS = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] action,
    input  logic [5:0] handle,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] status,
    output logic [5:0] handle_out,
    output logic [5:0] slot,
    output logic       move_valid,
    output logic [5:0] move_from,
    output logic [6:0] used_count
);

    cmd_t cmd;
    sts_t sts;

    hsmc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    hsmc_datapath #(
        .SLOTS (SLOTS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .action     (action),
        .handle     (handle),
        .status     (status),
        .handle_out (handle_out),
        .slot       (slot),
        .move_valid (move_valid),
        .move_from  (move_from),
        .used_count (used_count)
    );

endmodule

FILE: hw/rtl/hsmc_checker.sv
// Port checker for the handle-to-slot map compactor, bound to the top level.
// Depends on hsmc_pkg for the status codes.
module hsmc_checker import hsmc_pkg::*; #(
    parameter int SLOTS = 64
) (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [1:0] status,
    input logic [5:0] handle_out,
    input logic [5:0] slot,
    input logic       move_valid,
    input logic [5:0] move_from,
    input logic [6:0] used_count
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(handle_out)
            && $stable(slot) && $stable(move_valid) && $stable(move_from)
            && $stable(used_count))
        else $error("stalled result transaction changed");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (SLOTS > 127) || (32'(used_count) <= 32'(SLOTS)))
        else $error("used count above capacity");

    a_move_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && move_valid |-> (status == ST_OK)
            && ((SLOTS > 64) || ((move_from != slot) && ({1'b0, move_from} == used_count))))
        else $error("move transaction inconsistent");

    a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_OK) |-> !move_valid && (slot == 6'd0) && (move_from == 6'd0))
        else $error("failed transaction carries slot or move data");

endmodule

bind handle_slot_map_compactor_top hsmc_checker #(
    .SLOTS (SLOTS)
) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .handle_out (handle_out),
    .slot       (slot),
    .move_valid (move_valid),
    .move_from  (move_from),
    .used_count (used_count)
);
